// File: hw/rtl/ppcf_pkg.sv
// Shared types and constants for the pixel-perfect corner filter.
`timescale 1ns / 1ps
`default_nettype none

package ppcf_pkg;

	localparam int COORD_WIDTH = 16;

	typedef logic signed [COORD_WIDTH-1:0] coord_t;

	typedef enum logic [1:0] {
		CMD_PUSH   = 2'd0,
		CMD_FINISH = 2'd1,
		CMD_RESET  = 2'd2
	} cmd_t;

	typedef struct packed {
		cmd_t   cmd;
		coord_t point_x;
		coord_t point_y;
	} item_t;

	typedef struct packed {
		coord_t out_x;
		coord_t out_y;
	} result_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
	} point_t;

	// relation between two points
	typedef struct packed {
		logic step4;
		logic diag;
	} adj_t;

endpackage

`default_nettype wire

// File: hw/rtl/pixel_perfect_corner_filter_top.sv
// Top level of the pixel-perfect corner filter: input register, filter state, result register.
`timescale 1ns / 1ps
`default_nettype none

// Streaming corner filter for drawn pixel paths. Takes one command word per
// cycle (push, finish, reset) and releases at most one pixel word per input.
// A pushed point is held as pending until the next distinct point shows it is
// not the corner of an L step; finish flushes it, reset drops it. Throughput
// is one word per clock while results are taken, set by the single
// compare/subtract stage between the input register and the result register.
// A full result register that is not taken stalls the input register, and
// with it the input channel.

module pixel_perfect_corner_filter_top
	import ppcf_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_ready,
	input  item_t   item,
	output logic    result_valid,
	input  logic    result_ready,
	output result_t result
);

	// input register
	logic   item_valid_s1;
	item_t  item_s1;

	// filter state
	point_t pend_q;
	logic   pend_valid_q;
	point_t paint_q;
	logic   paint_valid_q;

	// result register
	logic    res_valid_q;
	result_t res_q;

	logic   advance;
	point_t new_pt;
	adj_t   rel_paint_pend;
	adj_t   rel_pend_new;
	adj_t   rel_paint_new;
	logic   same_pt;
	logic   corner;

	point_t pend_d;
	logic   pend_valid_d;
	point_t paint_d;
	logic   paint_valid_d;
	logic   emit;

	assign advance    = item_valid_s1 && (!res_valid_q || result_ready);
	assign item_ready = !item_valid_s1 || advance;

	assign new_pt.x = item_s1.point_x;
	assign new_pt.y = item_s1.point_y;

	ppcf_adj u_adj_paint_pend (.a(paint_q), .b(pend_q), .rel(rel_paint_pend));
	ppcf_adj u_adj_pend_new   (.a(pend_q),  .b(new_pt), .rel(rel_pend_new));
	ppcf_adj u_adj_paint_new  (.a(paint_q), .b(new_pt), .rel(rel_paint_new));

	assign same_pt = pend_valid_q && (pend_q == new_pt);
	assign corner  = paint_valid_q && rel_paint_pend.step4 && rel_pend_new.step4
		&& rel_paint_new.diag;

	always_comb begin
		pend_d        = pend_q;
		pend_valid_d  = pend_valid_q;
		paint_d       = paint_q;
		paint_valid_d = paint_valid_q;
		emit          = 1'b0;
		unique case (item_s1.cmd)
			CMD_PUSH: begin
				priority if (same_pt) begin
					// repeat of pending: drop the word
				end else if (!pend_valid_q) begin
					pend_d       = new_pt;
					pend_valid_d = 1'b1;
				end else if (corner) begin
					pend_d = new_pt;
				end else begin
					emit          = 1'b1;
					paint_d       = pend_q;
					paint_valid_d = 1'b1;
					pend_d        = new_pt;
				end
			end
			CMD_FINISH: begin
				emit          = pend_valid_q;
				pend_valid_d  = 1'b0;
				paint_valid_d = 1'b0;
			end
			CMD_RESET: begin
				pend_valid_d  = 1'b0;
				paint_valid_d = 1'b0;
			end
			default: begin
				// unused code: no effect
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (item_ready) begin
			item_valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_s1 <= '0;
		end else if (item_valid && item_ready) begin
			item_s1 <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q        <= '0;
			pend_valid_q  <= 1'b0;
			paint_q       <= '0;
			paint_valid_q <= 1'b0;
			res_valid_q   <= 1'b0;
		end else begin
			if (advance) begin
				pend_q        <= pend_d;
				pend_valid_q  <= pend_valid_d;
				paint_q       <= paint_d;
				paint_valid_q <= paint_valid_d;
				res_valid_q   <= emit;
			end else if (result_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			res_q.out_x <= pend_q.x;
			res_q.out_y <= pend_q.y;
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

	// a painted point only exists while a point is pending
	a_paint_implies_pend: assert property (@(posedge clk) disable iff (!arst_n)
		paint_valid_q |-> pend_valid_q)
		else $error("painted valid without pending point");

	// released pixel is the point that was pending
	a_emit_is_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && emit) |=> (result_valid && result.out_x == $past(pend_q.x)
			&& result.out_y == $past(pend_q.y)))
		else $error("released pixel differs from pending point");

	// a stalled input word is held until it moves on
	a_s1_held: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid_s1 && !advance) |=> (item_valid_s1 && $stable(item_s1)))
		else $error("input register lost a stalled word");

	// repeated push leaves the filter state alone
	a_repeat_no_change: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && item_s1.cmd == CMD_PUSH && same_pt) |=>
			($stable(pend_q) && $stable(paint_q) && $stable(paint_valid_q)
			&& !result_valid))
		else $error("repeated point changed state");

endmodule

`default_nettype wire

// File: hw/rtl/ppcf_adj.sv
// Adjacency check between two points: 4-neighbor step or diagonal touch.
`timescale 1ns / 1ps
`default_nettype none

module ppcf_adj
	import ppcf_pkg::*;
(
	input  point_t a,
	input  point_t b,
	output adj_t   rel
);

	localparam logic signed [COORD_WIDTH:0] ONE     = (COORD_WIDTH+1)'(1);
	localparam logic signed [COORD_WIDTH:0] NEG_ONE = -(COORD_WIDTH+1)'(1);
	localparam logic signed [COORD_WIDTH:0] ZERO    = '0;

	logic signed [COORD_WIDTH:0] dx;
	logic signed [COORD_WIDTH:0] dy;
	logic dx_one;
	logic dy_one;
	logic dx_zero;
	logic dy_zero;

	// one extra bit so ends of the range never wrap into neighbors
	assign dx = {a.x[COORD_WIDTH-1], a.x} - {b.x[COORD_WIDTH-1], b.x};
	assign dy = {a.y[COORD_WIDTH-1], a.y} - {b.y[COORD_WIDTH-1], b.y};

	assign dx_one  = (dx == ONE) || (dx == NEG_ONE);
	assign dy_one  = (dy == ONE) || (dy == NEG_ONE);
	assign dx_zero = (dx == ZERO);
	assign dy_zero = (dy == ZERO);

	assign rel.step4 = (dx_zero && dy_one) || (dx_one && dy_zero);
	assign rel.diag  = dx_one && dy_one;

endmodule

`default_nettype wire
